/* hw/rtl/tbls_pkg.sv */
// Package for the tile bin layout solver: field widths, register indexes,
// sequencer states and fixed limits. Used by tile_bin_layout_solver_core.
`default_nettype none

package tbls_pkg;

    localparam int GMEM_ALIGN_LOG2    = 12;
    localparam int MAX_TILES_PER_PIPE = 32;
    localparam int BIN_MIN_TILES      = 2;

    // Shared divider: numerator, denominator and quotient width.
    localparam int DIV_W = 25;
    localparam int CNT_W = 5;

    localparam int IN_W       = 88;
    localparam int OUT_W      = 120;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TILE_HEIGHT_ALIGN = 3'd0,
        CFG_TILE_MAX_WIDTH    = 3'd1,
        CFG_TILE_MAX_HEIGHT   = 3'd2,
        CFG_MAX_PIPES         = 3'd3,
        CFG_FORCE_BINNING     = 3'd4,
        CFG_DISABLE_BINNING   = 3'd5
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_ALIGN,
        ST_MAXW,
        ST_MAXH,
        ST_WMUL,
        ST_HDIV,
        ST_HALIGN,
        ST_HCHK,
        ST_NX,
        ST_NY,
        ST_Q,
        ST_H2,
        ST_NMUL,
        ST_CMP,
        ST_WNEXT,
        ST_FORCE_W,
        ST_FTW,
        ST_FORCE_H,
        ST_FTH,
        ST_PINIT,
        ST_PMUL,
        ST_PCHK,
        ST_PCW,
        ST_PCH,
        ST_BMUL1,
        ST_BMUL2,
        ST_BIN,
        ST_DIV
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/tile_bin_layout_solver_core.sv */
// Tile bin layout solver: sequencer around one shared multiplier and one
// shared restoring divider. Depends on tbls_pkg.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+------------------------------
//  s_      | in  | s_tvalid / s_tready       | s_tdata, 88 bits
//  m_      | out | m_tvalid / m_tready       | m_tdata, 120 bits
//  cfg_    | in  | cfg_valid / cfg_ready     | cfg_addr, cfg_data
//
// Every division runs on the shared divider at one quotient bit per cycle.
// s_tready is high only while the sequencer is idle; the result register lets
// the next item start while a result waits. Reset is synchronous; it sets the
// configuration registers to their reset values, clears m_tvalid and returns
// the sequencer to idle.
`default_nettype none

module tile_bin_layout_solver_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // fb_width, fb_height, fb_layer_count, view_count, tile_mem_pixels,
    // tile_width_align, min_bytes_per_pixel
    input  wire logic [tbls_pkg::IN_W-1:0]         s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tiling_possible, tile_width, tile_height, tiles_across, tiles_down,
    // pipe_tiles_across, pipe_tiles_down, pipes_across, pipes_down,
    // binning_possible, binning_used, zero fill
    output logic [tbls_pkg::OUT_W-1:0]             m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tbls_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [tbls_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tbls_pkg::*;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [8:0]  tha_reg;
    logic [12:0] tmw_reg, tmh_reg;
    logic [5:0]  maxp_reg;
    logic        force_reg, disable_reg;

    logic [14:0] fw_reg, fh_reg;
    logic [11:0] layers_reg;
    logic [23:0] pix_reg;
    logic [8:0]  aw_reg;
    logic [6:0]  cpp_reg;
    logic [20:0] ah_reg;

    logic [DIV_W-1:0] quo_reg, rem_reg, den_reg, num_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [32:0]      mul_p_reg;

    logic [12:0] maxw_reg, maxh_reg;
    logic [13:0] w_reg;
    logic [21:0] h_reg;
    logic [14:0] nx_reg, ny_reg;
    logic        possible_reg;
    logic [12:0] tw_reg;
    logic [21:0] th_reg;
    logic [14:0] cw_reg, ch_reg;
    logic [29:0] best_reg;
    logic [21:0] bdiff_reg;
    logic [14:0] pw_reg, ph_reg, pcw_reg, pch_reg;
    logic        binok_reg;
    logic        m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    logic [DIV_W-1:0] quo_next, rem_next, den_next, num_next;
    logic [CNT_W-1:0] cnt_next;
    logic [12:0] maxw_next, maxh_next;
    logic [13:0] w_next;
    logic [21:0] h_next;
    logic [14:0] nx_next, ny_next;
    logic        possible_next;
    logic [12:0] tw_next;
    logic [21:0] th_next;
    logic [14:0] cw_next, ch_next;
    logic [29:0] best_next;
    logic [21:0] bdiff_next;
    logic [14:0] pw_next, ph_next, pcw_next, pch_next;
    logic        binok_next;
    logic [20:0] ah_next;
    logic        m_valid_next;
    logic [OUT_W-1:0] m_data_next;

    // Shared units
    logic [17:0]      mul_a;
    logic [14:0]      mul_b;
    logic             div_go;
    logic [DIV_W-1:0] div_num, div_den;
    logic [DIV_W:0]   trial;
    logic             trial_ge;
    logic [DIV_W:0]   rup;

    // Item decode
    logic [14:0] in_fw, in_fh;
    logic [11:0] in_lay, in_layers;
    logic [5:0]  in_views;
    logic [8:0]  in_aw, ah0;
    logic [5:0]  limit;
    logic [3:0]  lz;
    logic [24:0] stride;
    logic [21:0] h_floor;
    logic [21:0] cur_diff;
    logic        take_best;
    logic        force_w_go, force_h_go, out_free, in_accept;
    logic [12:0] half_tw;
    logic [21:0] half_th;
    logic        bin_used;

    assign in_fw    = (s_tdata[14:0] == 15'd0) ? 15'd1 : s_tdata[14:0];
    assign in_fh    = (s_tdata[29:15] == 15'd0) ? 15'd1 : s_tdata[29:15];
    assign in_lay   = s_tdata[41:30];
    assign in_views = s_tdata[47:42];
    assign in_aw    = (s_tdata[80:72] == 9'd0) ? 9'd1 : s_tdata[80:72];
    always_comb begin
        in_layers = (in_lay > {6'd0, in_views}) ? in_lay : {6'd0, in_views};
        if (in_layers == 12'd0) begin
            in_layers = 12'd1;
        end
    end

    assign ah0   = (tha_reg == 9'd0) ? 9'd1 : tha_reg;
    assign limit = (maxp_reg == 6'd0) ? 6'd1 : maxp_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;

    // Divider step: one quotient bit per cycle.
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});
    // Numerator rounded up to a multiple of the denominator.
    assign rup = {1'b0, num_reg} +
                 ((rem_reg != '0) ? ({1'b0, den_reg} - {1'b0, rem_reg}) : '0);
    assign h_floor = num_reg[21:0] - rem_reg[21:0];

    assign stride = mul_p_reg[24:0];
    always_comb begin
        lz = 4'd0;
        for (int i = GMEM_ALIGN_LOG2 - 1; i >= 0; i--) begin
            if (stride[i]) begin
                lz = 4'(i);
            end
        end
    end

    assign cur_diff  = ({8'd0, w_reg} > h_reg) ? ({8'd0, w_reg} - h_reg)
                                               : (h_reg - {8'd0, w_reg});
    assign take_best = !possible_reg || (mul_p_reg[29:0] < best_reg) ||
                       ((mul_p_reg[29:0] == best_reg) && (cur_diff < bdiff_reg));

    assign force_w_go = force_reg && possible_reg && (cw_reg == 15'd1) &&
                        (tw_reg != {4'd0, aw_reg});
    assign force_h_go = force_reg && possible_reg && (ch_reg == 15'd1) &&
                        (th_reg != {1'b0, ah_reg});
    assign half_tw = 13'(({1'b0, tw_reg} + 14'd1) >> 1);
    assign half_th = 22'(({1'b0, th_reg} + 23'd1) >> 1);
    assign bin_used = binok_reg && (force_reg ||
                      (mul_p_reg > 33'(BIN_MIN_TILES))) && !disable_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_MUL1;
            ST_MUL1:    state_next = ST_MUL2;
            ST_MUL2:    state_next = ST_ALIGN;
            ST_ALIGN: begin
                if (pix_reg == 24'd0) begin
                    state_next = ST_PINIT;
                end else begin
                    state_next = ST_DIV;
                    ret_next   = ST_MAXW;
                end
            end
            ST_MAXW: begin
                state_next = ST_DIV;
                ret_next   = ST_MAXH;
            end
            ST_MAXH: begin
                state_next = ({4'd0, aw_reg} > maxw_reg) ? ST_FORCE_W : ST_WMUL;
            end
            ST_WMUL:    state_next = ST_HDIV;
            ST_HDIV: begin
                state_next = ST_DIV;
                ret_next   = ST_HALIGN;
            end
            ST_HALIGN: begin
                state_next = ST_DIV;
                ret_next   = ST_HCHK;
            end
            ST_HCHK: begin
                if (h_floor == 22'd0) begin
                    state_next = ST_WNEXT;
                end else begin
                    state_next = ST_DIV;
                    ret_next   = ST_NX;
                end
            end
            ST_NX: begin
                state_next = ST_DIV;
                ret_next   = ST_NY;
            end
            ST_NY: begin
                state_next = ST_DIV;
                ret_next   = ST_Q;
            end
            ST_Q: begin
                state_next = ST_DIV;
                ret_next   = ST_H2;
            end
            ST_H2:      state_next = ST_NMUL;
            ST_NMUL:    state_next = ST_CMP;
            ST_CMP:     state_next = ST_WNEXT;
            ST_WNEXT: begin
                state_next = ((w_reg + {5'd0, aw_reg}) > {1'b0, maxw_reg}) ?
                             ST_FORCE_W : ST_WMUL;
            end
            ST_FORCE_W: begin
                if (force_w_go) begin
                    state_next = ST_DIV;
                    ret_next   = ST_FTW;
                end else begin
                    state_next = ST_FORCE_H;
                end
            end
            ST_FTW:     state_next = ST_FORCE_H;
            ST_FORCE_H: begin
                if (force_h_go) begin
                    state_next = ST_DIV;
                    ret_next   = ST_FTH;
                end else begin
                    state_next = ST_PINIT;
                end
            end
            ST_FTH:     state_next = ST_PINIT;
            ST_PINIT:   state_next = ST_PMUL;
            ST_PMUL:    state_next = ST_PCHK;
            ST_PCHK: begin
                if (mul_p_reg > {27'd0, limit}) begin
                    state_next = ST_DIV;
                    ret_next   = (pw_reg < ph_reg) ? ST_PCW : ST_PCH;
                end else begin
                    state_next = ST_BMUL1;
                end
            end
            ST_PCW:     state_next = ST_PMUL;
            ST_PCH:     state_next = ST_PMUL;
            ST_BMUL1:   state_next = ST_BMUL2;
            ST_BMUL2:   state_next = ST_BIN;
            ST_BIN:     if (out_free) state_next = ST_IDLE;
            ST_DIV:     if (cnt_reg == '0) state_next = ret_reg;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Operand selection for the shared units
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        div_go  = 1'b0;
        div_num = '0;
        div_den = '0;
        unique case (state_reg)
            ST_MUL1: begin
                mul_a = {9'd0, ah0};
                mul_b = {6'd0, aw_reg};
            end
            ST_MUL2: begin
                mul_a = mul_p_reg[17:0];
                mul_b = {8'd0, cpp_reg};
            end
            ST_ALIGN: begin
                div_go  = 1'b1;
                div_num = {10'd0, fw_reg};
                div_den = {16'd0, aw_reg};
            end
            ST_MAXW: begin
                div_go  = 1'b1;
                div_num = {10'd0, fh_reg};
                div_den = {4'd0, ah_reg};
            end
            ST_WMUL: begin
                mul_a = {4'd0, w_reg};
                mul_b = {3'd0, layers_reg};
            end
            ST_HDIV: begin
                div_go  = 1'b1;
                div_num = {1'b0, pix_reg};
                div_den = mul_p_reg[DIV_W-1:0];
            end
            ST_HALIGN: begin
                div_go  = 1'b1;
                div_num = (quo_reg > {12'd0, maxh_reg}) ? {12'd0, maxh_reg} : quo_reg;
                div_den = {4'd0, ah_reg};
            end
            ST_HCHK: begin
                div_go  = 1'b1;
                div_num = {10'd0, fw_reg} + {11'd0, w_reg} - 25'd1;
                div_den = {11'd0, w_reg};
            end
            ST_NX: begin
                div_go  = 1'b1;
                div_num = {10'd0, fh_reg} + {3'd0, h_reg} - 25'd1;
                div_den = {3'd0, h_reg};
            end
            ST_NY: begin
                div_go  = 1'b1;
                div_num = {10'd0, fh_reg} + quo_reg - 25'd1;
                div_den = quo_reg;
            end
            ST_Q: begin
                div_go  = 1'b1;
                div_num = quo_reg;
                div_den = {4'd0, ah_reg};
            end
            ST_NMUL, ST_PMUL: begin
                mul_a = (state_reg == ST_NMUL) ? {3'd0, nx_reg} : {3'd0, pcw_reg};
                mul_b = (state_reg == ST_NMUL) ? ny_reg : pch_reg;
            end
            ST_FORCE_W: begin
                div_go  = force_w_go;
                div_num = {12'd0, half_tw};
                div_den = {16'd0, aw_reg};
            end
            ST_FORCE_H: begin
                div_go  = force_h_go;
                div_num = {3'd0, half_th};
                div_den = {4'd0, ah_reg};
            end
            ST_PCHK: begin
                div_go = (mul_p_reg > {27'd0, limit});
                if (pw_reg < ph_reg) begin
                    div_num = {10'd0, cw_reg} + {10'd0, pw_reg};
                    div_den = {10'd0, pw_reg} + 25'd1;
                end else begin
                    div_num = {10'd0, ch_reg} + {10'd0, ph_reg};
                    div_den = {10'd0, ph_reg} + 25'd1;
                end
            end
            ST_BMUL1: begin
                mul_a = {3'd0, pw_reg};
                mul_b = ph_reg;
            end
            ST_BMUL2: begin
                mul_a = {3'd0, cw_reg};
                mul_b = ch_reg;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // Datapath register updates
    always_comb begin
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        num_next      = num_reg;
        cnt_next      = cnt_reg;
        maxw_next     = maxw_reg;
        maxh_next     = maxh_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        nx_next       = nx_reg;
        ny_next       = ny_reg;
        possible_next = possible_reg;
        tw_next       = tw_reg;
        th_next       = th_reg;
        cw_next       = cw_reg;
        ch_next       = ch_reg;
        best_next     = best_reg;
        bdiff_next    = bdiff_reg;
        pw_next       = pw_reg;
        ph_next       = ph_reg;
        pcw_next      = pcw_reg;
        pch_next      = pch_reg;
        binok_next    = binok_reg;
        ah_next       = ah_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;

        if (state_reg == ST_DIV) begin
            rem_next = trial_ge ? DIV_W'(trial - {1'b0, den_reg}) : trial[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], trial_ge};
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (div_go) begin
            quo_next = div_num;
            num_next = div_num;
            den_next = div_den;
            rem_next = '0;
            cnt_next = CNT_W'(DIV_W - 1);
        end

        case (state_reg)
            ST_IDLE: begin
                possible_next = 1'b0;
                tw_next       = 13'hFFF;
                th_next       = 22'hFFF;
                cw_next       = 15'd1;
                ch_next       = 15'd1;
            end
            ST_ALIGN: begin
                ah_next = {12'd0, ah0};
                // Widen the height alignment so the layer stride is 4 KiB aligned.
                if ((layers_reg > 12'd1) && (stride[GMEM_ALIGN_LOG2-1:0] != '0)) begin
                    ah_next = {12'd0, ah0} << (4'(GMEM_ALIGN_LOG2) - lz);
                end
            end
            ST_MAXW: maxw_next = (rup > {13'd0, tmw_reg}) ? tmw_reg : rup[12:0];
            ST_MAXH: begin
                maxh_next = (rup > {13'd0, tmh_reg}) ? tmh_reg : rup[12:0];
                w_next    = {5'd0, aw_reg};
            end
            ST_HALIGN: h_next = div_num[21:0];
            ST_HCHK:   h_next = h_floor;
            ST_NX:     nx_next = quo_reg[14:0];
            ST_NY:     ny_next = quo_reg[14:0];
            ST_H2:     h_next = rup[21:0];
            ST_CMP: begin
                if (take_best) begin
                    possible_next = 1'b1;
                    tw_next       = w_reg[12:0];
                    th_next       = h_reg;
                    cw_next       = nx_reg;
                    ch_next       = ny_reg;
                    best_next     = mul_p_reg[29:0];
                    bdiff_next    = cur_diff;
                end
            end
            ST_WNEXT:  w_next = w_reg + {5'd0, aw_reg};
            ST_FTW: begin
                tw_next = rup[12:0];
                cw_next = 15'd2;
            end
            ST_FTH: begin
                th_next = rup[21:0];
                ch_next = 15'd2;
            end
            ST_PINIT: begin
                pcw_next = cw_reg;
                pch_next = ch_reg;
                pw_next  = 15'd1;
                ph_next  = 15'd1;
            end
            ST_PCHK: begin
                if (mul_p_reg > {27'd0, limit}) begin
                    if (pw_reg < ph_reg) begin
                        pw_next = pw_reg + 15'd1;
                    end else begin
                        ph_next = ph_reg + 15'd1;
                    end
                end
            end
            ST_PCW:   pcw_next = quo_reg[14:0];
            ST_PCH:   pch_next = quo_reg[14:0];
            ST_BMUL2: binok_next = (mul_p_reg <= 33'(MAX_TILES_PER_PIPE));
            ST_BIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'd0, bin_used, binok_reg, pch_reg, pcw_reg,
                                    ph_reg, pw_reg, ch_reg, cw_reg, th_reg[11:0],
                                    tw_reg[11:0], possible_reg};
                end
            end
            default: begin
                m_data_next = m_data_next;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            m_valid_reg <= 1'b0;
            tha_reg     <= 9'd16;
            tmw_reg     <= 13'd1024;
            tmh_reg     <= 13'd1008;
            maxp_reg    <= 6'd32;
            force_reg   <= 1'b0;
            disable_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_addr))
                    CFG_TILE_HEIGHT_ALIGN: tha_reg     <= cfg_data[8:0];
                    CFG_TILE_MAX_WIDTH:    tmw_reg     <= cfg_data;
                    CFG_TILE_MAX_HEIGHT:   tmh_reg     <= cfg_data;
                    CFG_MAX_PIPES:         maxp_reg    <= cfg_data[5:0];
                    CFG_FORCE_BINNING:     force_reg   <= cfg_data[0];
                    CFG_DISABLE_BINNING:   disable_reg <= cfg_data[0];
                    default:               tha_reg     <= tha_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            fw_reg     <= in_fw;
            fh_reg     <= in_fh;
            layers_reg <= in_layers;
            pix_reg    <= s_tdata[71:48];
            aw_reg     <= in_aw;
            cpp_reg    <= s_tdata[87:81];
        end
        mul_p_reg    <= {15'd0, mul_a} * {18'd0, mul_b};
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        cnt_reg      <= cnt_next;
        maxw_reg     <= maxw_next;
        maxh_reg     <= maxh_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
        possible_reg <= possible_next;
        tw_reg       <= tw_next;
        th_reg       <= th_next;
        cw_reg       <= cw_next;
        ch_reg       <= ch_next;
        best_reg     <= best_next;
        bdiff_reg    <= bdiff_next;
        pw_reg       <= pw_next;
        ph_reg       <= ph_next;
        pcw_reg      <= pcw_next;
        pch_reg      <= pch_next;
        binok_reg    <= binok_next;
        ah_reg       <= ah_next;
        m_data_reg   <= m_data_next;
    end

`ifndef ASSERT_OFF
    // Once an item is taken, the solver is busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again right after a transfer");

    // The shared divider never runs with a zero denominator.
    a_div_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (den_reg != '0))
        else $error("divider started with a zero denominator");

    // An impossible layout is reported with all-ones tile sizes.
    a_impossible_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg[0]) |-> (m_data_reg[24:1] == 24'hFFFFFF))
        else $error("impossible layout with a real tile size");

    // The tiles-across and pipe-tiles-across counts are never zero.
    a_counts_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[39:25] != 15'd0 && m_data_reg[69:55] != 15'd0))
        else $error("zero tile or pipe count in a result");
`endif

endmodule

`default_nettype wire

/* dv/tb_tile_bin_layout_solver_core.sv */
// Self-checking testbench for tile_bin_layout_solver_core: drives framebuffer
// descriptions, predicts each tile layout in SystemVerilog and checks results.
// Depends on tbls_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_tile_bin_layout_solver_core;
    import tbls_pkg::*;

    typedef struct {
        logic [14:0] fb_width;
        logic [14:0] fb_height;
        logic [11:0] fb_layers;
        logic [5:0]  views;
        logic [23:0] mem_pixels;
        logic [8:0]  width_align;
        logic [6:0]  bpp;
    } fb_desc_t;

    typedef struct {
        logic        possible;
        logic [11:0] tile_w;
        logic [11:0] tile_h;
        logic [14:0] tiles_x;
        logic [14:0] tiles_y;
        logic [14:0] ptiles_x;
        logic [14:0] ptiles_y;
        logic [14:0] pipes_x;
        logic [14:0] pipes_y;
        logic        bin_ok;
        logic        bin_used;
    } layout_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the configuration registers.
    logic [8:0]  sh_height_align = 9'd16;
    logic [12:0] sh_max_w = 13'd1024;
    logic [12:0] sh_max_h = 13'd1008;
    logic [5:0]  sh_max_pipes = 6'd32;
    logic        sh_force = 1'b0;
    logic        sh_disable = 1'b0;

    layout_t pending_layouts[$];
    int      errors = 0;
    bit      calm = 1'b0;
    int      hold_cycles = 0;

    always #6 aclk = ~aclk;

    tile_bin_layout_solver_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    function automatic int unsigned div_up(int unsigned v, int unsigned d);
        return (v + d - 1) / d;
    endfunction

    function automatic int unsigned abs_diff(int unsigned a, int unsigned b);
        return a > b ? a - b : b - a;
    endfunction

    // Computes the layout for one description; cost is a rough cycle estimate.
    function automatic void solve_layout(input fb_desc_t d, output layout_t r,
                                         output int cost);
        int unsigned fw, fh, aw, ah, layers, lim, stride, maxw, maxh, w, h, nx, ny;
        int unsigned tw, th, cw, ch, pw, ph, pcw, pch, lz;
        longint unsigned best, n;
        bit possible, ok, bin;
        fw = d.fb_width == 0 ? 1 : d.fb_width;
        fh = d.fb_height == 0 ? 1 : d.fb_height;
        aw = d.width_align == 0 ? 1 : d.width_align;
        ah = sh_height_align == 0 ? 1 : sh_height_align;
        layers = d.fb_layers > d.views ? d.fb_layers : d.views;
        if (layers == 0) layers = 1;
        lim = sh_max_pipes == 0 ? 1 : sh_max_pipes;
        tw = 12'hFFF; th = 12'hFFF; cw = 1; ch = 1; pw = 1; ph = 1;
        best = '1;
        possible = 1'b0;
        cost = 60;
        stride = ah * aw * d.bpp;
        if (layers > 1 && (stride & 32'hFFF) != 0) begin
            lz = 0;
            while (lz < 31 && stride[lz] == 1'b0) lz++;
            ah = ah << (GMEM_ALIGN_LOG2 - lz);
        end
        if (d.mem_pixels != 0) begin
            maxw = div_up(fw, aw) * aw;
            if (sh_max_w < maxw) maxw = sh_max_w;
            maxh = div_up(fh, ah) * ah;
            if (sh_max_h < maxh) maxh = sh_max_h;
            for (w = aw; w <= maxw; w += aw) begin
                cost += 170;
                h = d.mem_pixels / (w * layers);
                if (h > maxh) h = maxh;
                h = (h / ah) * ah;
                if (h == 0) continue;
                nx = div_up(fw, w);
                ny = div_up(fh, h);
                h = div_up(div_up(fh, ny), ah) * ah;
                n = longint'(nx) * ny;
                if (n < best || (n == best && abs_diff(w, h) < abs_diff(tw, th))) begin
                    possible = 1'b1;
                    tw = w; th = h; cw = nx; ch = ny; best = n;
                end
            end
            if (sh_force && possible) begin
                if (cw == 1 && tw != aw) begin
                    tw = div_up(div_up(tw, 2), aw) * aw;
                    cw = 2;
                end
                if (ch == 1 && th != ah) begin
                    th = div_up(div_up(th, 2), ah) * ah;
                    ch = 2;
                end
            end
        end
        if (!possible) begin
            tw = 12'hFFF; th = 12'hFFF; cw = 1; ch = 1;
        end
        pcw = cw; pch = ch;
        while (longint'(pcw) * pch > lim) begin
            cost += 35;
            if (pw < ph) begin
                pw++;
                pcw = div_up(cw, pw);
            end else begin
                ph++;
                pch = div_up(ch, ph);
            end
        end
        ok = longint'(pw) * ph <= MAX_TILES_PER_PIPE;
        bin = 1'b0;
        if (ok) begin
            bin = longint'(cw) * ch > BIN_MIN_TILES;
            if (sh_force) bin = 1'b1;
            if (sh_disable) bin = 1'b0;
        end
        r.possible = possible;
        r.tile_w = tw[11:0]; r.tile_h = th[11:0];
        r.tiles_x = cw[14:0]; r.tiles_y = ch[14:0];
        r.ptiles_x = pw[14:0]; r.ptiles_y = ph[14:0];
        r.pipes_x = pcw[14:0]; r.pipes_y = pch[14:0];
        r.bin_ok = ok; r.bin_used = bin;
    endfunction

    // Receiver: random stalls, a long hold-off on request, none in the calm part.
    initial begin : ready_driver
        int burst;
        burst = 0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        layout_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_layouts.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transfer, actual %h", $time, m_tdata);
            end else begin
                e = pending_layouts.pop_front();
                check_field("tiling_possible", e.possible, m_tdata[0]);
                check_field("tile_width", e.tile_w, m_tdata[12:1]);
                check_field("tile_height", e.tile_h, m_tdata[24:13]);
                check_field("tiles_across", e.tiles_x, m_tdata[39:25]);
                check_field("tiles_down", e.tiles_y, m_tdata[54:40]);
                check_field("pipe_tiles_across", e.ptiles_x, m_tdata[69:55]);
                check_field("pipe_tiles_down", e.ptiles_y, m_tdata[84:70]);
                check_field("pipes_across", e.pipes_x, m_tdata[99:85]);
                check_field("pipes_down", e.pipes_y, m_tdata[114:100]);
                check_field("binning_possible", e.bin_ok, m_tdata[115]);
                check_field("binning_used", e.bin_used, m_tdata[116]);
                check_field("zero fill", 0, m_tdata[119:117]);
            end
        end
    end

    task automatic send_desc(fb_desc_t d);
        layout_t r;
        int cost;
        s_tvalid <= 1'b1;
        s_tdata <= {d.bpp, d.width_align, d.mem_pixels, d.views, d.fb_layers,
                    d.fb_height, d.fb_width};
        do @(posedge aclk); while (!s_tready);
        solve_layout(d, r, cost);
        pending_layouts.push_back(r);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic send_fields(int fw, int fh, int lay, int vw, int pix, int aw, int bpp);
        fb_desc_t d;
        d.fb_width = fw; d.fb_height = fh; d.fb_layers = lay; d.views = vw;
        d.mem_pixels = pix; d.width_align = aw; d.bpp = bpp;
        send_desc(d);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (pending_layouts.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TILE_HEIGHT_ALIGN: sh_height_align = val[8:0];
            CFG_TILE_MAX_WIDTH:    sh_max_w = val[12:0];
            CFG_TILE_MAX_HEIGHT:   sh_max_h = val[12:0];
            CFG_MAX_PIPES:         sh_max_pipes = val[5:0];
            CFG_FORCE_BINNING:     sh_force = val[0];
            CFG_DISABLE_BINNING:   sh_disable = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(int ha, int mw, int mh, int mp, int fb, int db);
        wait_drained();
        write_reg(CFG_TILE_HEIGHT_ALIGN, ha);
        write_reg(CFG_TILE_MAX_WIDTH, mw);
        write_reg(CFG_TILE_MAX_HEIGHT, mh);
        write_reg(CFG_MAX_PIPES, mp);
        write_reg(CFG_FORCE_BINNING, fb);
        write_reg(CFG_DISABLE_BINNING, db);
    endtask

    // Random description whose solve stays cheap; sizes are mostly small.
    function automatic fb_desc_t random_desc();
        fb_desc_t d;
        layout_t r;
        int cost;
        for (int tries = 0; tries < 300; tries++) begin
            case ($urandom_range(0, 3))
                0: d.fb_width = $urandom_range(0, 64);
                1, 2: d.fb_width = $urandom_range(1, 2048);
                default: d.fb_width = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0: d.fb_height = $urandom_range(0, 64);
                1, 2: d.fb_height = $urandom_range(1, 2048);
                default: d.fb_height = $urandom;
            endcase
            d.fb_layers = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4);
            d.views = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2);
            case ($urandom_range(0, 5))
                0: d.mem_pixels = 0;
                1: d.mem_pixels = $urandom_range(1, 4096);
                default: d.mem_pixels = $urandom;
            endcase
            d.width_align = $urandom_range(0, 1) ? $urandom : (1 << $urandom_range(0, 8));
            d.bpp = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 16);
            solve_layout(d, r, cost);
            if (cost <= 3000) return d;
        end
        d.fb_width = 1; d.fb_height = 1; d.fb_layers = 1; d.views = 0;
        d.mem_pixels = 24'hFFFFFF; d.width_align = 1; d.bpp = 4;
        return d;
    endfunction

    task automatic test_defaults_directed();
        send_fields(1, 1, 1, 0, 24'hFFFFFF, 1, 1);
        send_fields(0, 0, 0, 0, 1000, 0, 0);
        send_fields(100, 100, 1, 0, 0, 16, 4);
        send_fields(16384, 16384, 1, 0, 24'hFFFFFF, 256, 64);
        send_fields(32767, 32767, 12'hFFF, 6'h3F, 24'hFFFFFF, 9'h1FF, 7'h7F);
        send_fields(1920, 1080, 2, 0, 1 << 20, 256, 4);
        send_fields(64, 64, 1, 32, 1 << 18, 32, 3);
        send_fields(300, 200, 2048, 0, 24'hFFFFFF, 256, 2);
        send_fields(256, 256, 1, 0, 10, 64, 4);
        send_fields(512, 64, 1, 0, 65536, 128, 1);
    endtask

    task automatic test_force_and_disable();
        set_config(16, 1024, 1008, 32, 1, 0);
        send_fields(64, 64, 1, 0, 24'hFFFFFF, 16, 4);
        send_fields(16, 16, 1, 0, 24'hFFFFFF, 16, 4);
        send_fields(100, 100, 1, 0, 0, 32, 4);
        set_config(16, 1024, 1008, 32, 1, 1);
        send_fields(64, 64, 1, 0, 24'hFFFFFF, 16, 4);
        send_fields(512, 512, 1, 0, 4096, 64, 4);
    endtask

    task automatic test_register_extremes();
        set_config(256, 4096, 4096, 1, 0, 0);
        send_fields(1024, 4096, 1, 0, 24'hFFFFFF, 256, 4);
        send_fields(2048, 2048, 3, 0, 200000, 256, 3);
        set_config(1, 1, 1, 63, 0, 0);
        send_fields(4, 4, 1, 0, 24'hFFFFFF, 1, 1);
        set_config(0, 13'h1FFF, 13'h1FFF, 0, 0, 0);
        send_fields(512, 300, 2, 0, 500000, 256, 5);
        send_fields(200, 200, 1, 0, 4000, 128, 1);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 8; ph++) begin
            set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            if (ph == 3) hold_cycles = 3000;
            for (int i = 0; i < 90; i++) send_desc(random_desc());
        end
        set_config(16, 1024, 1008, 32, 0, 0);
        calm = 1'b1;
        for (int i = 0; i < 80; i++) send_desc(random_desc());
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults_directed();
        test_force_and_disable();
        test_register_extremes();
        test_random_phases();
        wait_drained();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
